// ===== rtl/core/grid_line_rasterizer_unit_assert.svh =====
// Assertion macros for the line rasterizer checker.
`ifndef GRID_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define GRID_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

// ===== rtl/core/gla_pkg.sv =====
// Shared types and constants of the grid line rasterizer.
package gla_pkg;

    localparam int COORD_BITS = 5;
    localparam int FIELD_W    = 5;
    localparam int ERR_W      = COORD_BITS + 3;
    localparam int CNT_W      = COORD_BITS + 2;

    localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic signed [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    typedef enum logic {
        MODE_POINTS = 1'b0,
        MODE_LINE   = 1'b1
    } t_mode;

    typedef struct packed {
        logic [FIELD_W-1:0] start_x;
        logic [FIELD_W-1:0] start_y;
        logic [FIELD_W-1:0] end_x;
        logic [FIELD_W-1:0] end_y;
        logic [7:0]         glyph;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] tile_x;
        logic [FIELD_W-1:0] tile_y;
        logic [7:0]         tile_glyph;
        logic               last_tile;
    } t_out;

    // Classified line command handed from the front to the walker.
    typedef struct packed {
        t_mode                   mode;
        logic [COORD_BITS-1:0]   sx;
        logic [COORD_BITS-1:0]   sy;
        logic [COORD_BITS-1:0]   ex;
        logic [COORD_BITS-1:0]   ey;
        logic                    x_neg;
        logic                    y_neg;
        logic signed [ERR_W-1:0] err0;
        logic signed [ERR_W-1:0] dx2;
        logic signed [ERR_W-1:0] dy2;
        logic signed [CNT_W-1:0] count0;
        logic [7:0]              glyph;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_cmdq_stat;

endpackage

// ===== rtl/core/gla_front.sv =====
// Front end: holds the mode register and classifies incoming line commands.
module gla_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  gla_pkg::t_in  i_item,
    output gla_pkg::t_cmd o_cmd
);
    import gla_pkg::*;

    t_mode                 r_draw_mode;
    logic [COORD_BITS-1:0] sx, sy, ex, ey, dx, dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_mode <= MODE_LINE;
        end else if (i_cfg_we) begin
            r_draw_mode <= t_mode'(i_cfg_wdata);
        end
    end

    always_comb begin
        sx = i_item.start_x[COORD_BITS-1:0];
        sy = i_item.start_y[COORD_BITS-1:0];
        ex = i_item.end_x[COORD_BITS-1:0];
        ey = i_item.end_y[COORD_BITS-1:0];
        dx = (ex > sx) ? ex - sx : sx - ex;
        dy = (ey > sy) ? ey - sy : sy - ey;

        o_cmd.mode   = r_draw_mode;
        o_cmd.sx     = sx;
        o_cmd.sy     = sy;
        o_cmd.ex     = ex;
        o_cmd.ey     = ey;
        o_cmd.x_neg  = !(ex > sx);
        o_cmd.y_neg  = !(ey > sy);
        o_cmd.err0   = signed'(ERR_W'(dx)) - signed'(ERR_W'(dy));
        o_cmd.dx2    = signed'(ERR_W'({dx, 1'b0}));
        o_cmd.dy2    = signed'(ERR_W'({dy, 1'b0}));
        o_cmd.count0 = signed'(CNT_W'(dx) + CNT_W'(dy) + CNT_W'(1));
        o_cmd.glyph  = i_item.glyph;
    end

endmodule

// ===== rtl/core/gla_cmd_queue.sv =====
// Two-entry command queue between the front end and the walker.
module gla_cmd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gla_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output gla_pkg::t_cmd       o_cmd,
    output gla_pkg::t_cmdq_stat o_stat
);
    import gla_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/gla_walker.sv =====
// Back end: walks each command tile by tile into a registered result slot.
module gla_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gla_pkg::t_cmd       i_cmd,
    input  gla_pkg::t_cmdq_stat i_stat,
    output logic                o_cmd_pop,
    output gla_pkg::t_out       o_result,
    output logic                o_empty,
    input  logic                i_pop
);
    import gla_pkg::*;

    logic                    r_busy, r_ov, r_phase;
    t_cmd                    r_cmd;
    logic [COORD_BITS-1:0]   r_x, r_y;
    logic signed [ERR_W-1:0] r_err;
    logic signed [CNT_W-1:0] r_count;
    t_out                    r_out;

    logic                    adv, load, tile_last;
    logic [COORD_BITS-1:0]   n_x, n_y, step_x, step_y;
    logic signed [ERR_W-1:0] n_err;
    logic signed [CNT_W-1:0] n_count;
    t_out                    tile;

    assign load      = !r_busy && !i_stat.empty;
    assign adv       = r_busy && (!r_ov || i_pop);
    assign o_cmd_pop = load;
    assign o_empty   = !r_ov;
    assign o_result  = r_out;

    always_comb begin
        step_x = r_cmd.x_neg ? r_x - COORD_BITS'(1) : r_x + COORD_BITS'(1);
        step_y = r_cmd.y_neg ? r_y - COORD_BITS'(1) : r_y + COORD_BITS'(1);
        n_x     = r_x;
        n_y     = r_y;
        n_err   = r_err;
        n_count = r_count;
        if (r_err == '0) begin
            n_x     = step_x;
            n_y     = step_y;
            n_err   = r_err + r_cmd.dx2 - r_cmd.dy2;
            n_count = r_count - CNT_TWO;
        end else if (r_err > 0) begin
            n_x     = step_x;
            n_err   = r_err - r_cmd.dy2;
            n_count = r_count - CNT_ONE;
        end else begin
            n_y     = step_y;
            n_err   = r_err + r_cmd.dx2;
            n_count = r_count - CNT_ONE;
        end

        tile.tile_glyph = r_cmd.glyph;
        if (r_cmd.mode == MODE_LINE) begin
            tile.tile_x = FIELD_W'(r_x);
            tile.tile_y = FIELD_W'(r_y);
            tile_last   = (n_count <= 0);
        end else if (r_phase) begin
            tile.tile_x = FIELD_W'(r_cmd.ex);
            tile.tile_y = FIELD_W'(r_cmd.ey);
            tile_last   = 1'b1;
        end else begin
            tile.tile_x = FIELD_W'(r_cmd.sx);
            tile.tile_y = FIELD_W'(r_cmd.sy);
            tile_last   = 1'b0;
        end
        tile.last_tile = tile_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (adv && tile_last) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Walk registers carry payload only; r_busy qualifies them.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd   <= i_cmd;
            r_x     <= i_cmd.sx;
            r_y     <= i_cmd.sy;
            r_err   <= i_cmd.err0;
            r_count <= i_cmd.count0;
            r_phase <= 1'b0;
        end else if (adv) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_err   <= n_err;
            r_count <= n_count;
            r_phase <= 1'b1;
        end
        if (adv) begin
            r_out <= tile;
        end
    end

endmodule

// ===== rtl/core/grid_line_rasterizer_unit.sv =====
// An accepted command goes from the command queue into the walker registers, then its
// first tile is registered into the result slot. Rate: one tile per cycle while the slot
// is free or popped; a load step lies between commands, and points mode gives two tiles.
// The walker loop (one error update per tile) sets the rate; a 2-entry command
// queue lets up to two further commands enter while a line is walked.
// Reset (synchronous, active low) empties both sides and sets draw_mode to full line.
module grid_line_rasterizer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          push,
    input  gla_pkg::t_in  i_item,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output gla_pkg::t_out o_result
);
    import gla_pkg::*;

    t_cmd       front_cmd;
    t_cmd       queue_cmd;
    t_cmdq_stat cmdq_stat;
    logic       cmd_pop;

    // Classify the incoming transaction and hold the mode register.
    gla_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .o_cmd       (front_cmd)
    );

    // Decouple acceptance from the walk; full back-pressures the source.
    gla_cmd_queue u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_cmd   (queue_cmd),
        .o_stat  (cmdq_stat)
    );

    assign full = cmdq_stat.full;

    // Walk one command at a time; the result register advances on pop.
    gla_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (queue_cmd),
        .i_stat    (cmdq_stat),
        .o_cmd_pop (cmd_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

// ===== rtl/core/gla_checker.sv =====
// Port-level checker for the grid line rasterizer, bound to the top level.
`include "grid_line_rasterizer_unit_assert.svh"

module gla_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          push,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input gla_pkg::t_out o_result
);

    logic       mid_pop;
    logic [7:0] glyph;

    assign mid_pop = !empty && pop && !o_result.last_tile;
    assign glyph   = o_result.tile_glyph;

    // A waiting result holds until popped.
    `GLA_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_result))

    // Within a line command the next tile follows a pop at once and keeps the glyph.
    `GLA_ASSERT_NEXT(a_tile_follows, i_clk, i_rst_n, mid_pop, !empty && (glyph == $past(glyph)))

    // The queue only fills through an accepted transaction.
    `GLA_ASSERT_NOW(a_full_by_push, i_clk, i_rst_n, $rose(full), $past(push && !full))

endmodule

bind grid_line_rasterizer_unit gla_checker u_gla_checker (.*);
